>>> design/phf_pkg.sv
// Shared constants and window-table functions for the pre-emphasis and Hamming framer.
package phf_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int VALUE_W  = 17;
    localparam int POS_W    = 9;
    localparam int COEFF_W  = 15;
    localparam int WIN_W    = 16;
    localparam int PROD_W   = 34;

    // Default framing
    localparam int FRAME_LEN_DEF = 1024;
    localparam int HOP_DEF       = 512;

    // Configuration
    localparam int                   APB_ADDR_W        = 3;
    localparam int                   APB_DATA_W        = 32;
    localparam logic                 REG_PREEMPH_COEFF = 1'b0;
    localparam logic [COEFF_W-1:0]   COEFF_RESET       = 15'd31130;

    // Fixed-point constants of the window
    localparam logic [63:0] Q30_ONE_U = 64'd1073741824;
    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam longint      Q30_ONE   = 64'sd1073741824;
    localparam longint      HAM_A_Q30 = 64'sd579820585;
    localparam longint      HAM_B_Q30 = 64'sd493921239;

    // Cosine of m/2^32 turns, m in [0, 2^30], Q30; Horner steps truncate and clamp at zero
    function automatic logic [63:0] quarter_cos(input logic [63:0] m);
        logic [63:0] a;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] sub;
        a   = (m * PI_Q30) >> 31;
        x2  = (a * a) >> 30;
        t   = Q30_ONE_U;
        sub = ((x2 * t) >> 30) / 64'd132;
        t   = (sub > Q30_ONE_U) ? 64'd0 : Q30_ONE_U - sub;
        sub = ((x2 * t) >> 30) / 64'd90;
        t   = (sub > Q30_ONE_U) ? 64'd0 : Q30_ONE_U - sub;
        sub = ((x2 * t) >> 30) / 64'd56;
        t   = (sub > Q30_ONE_U) ? 64'd0 : Q30_ONE_U - sub;
        sub = ((x2 * t) >> 30) / 64'd30;
        t   = (sub > Q30_ONE_U) ? 64'd0 : Q30_ONE_U - sub;
        sub = ((x2 * t) >> 30) / 64'd12;
        t   = (sub > Q30_ONE_U) ? 64'd0 : Q30_ONE_U - sub;
        sub = ((x2 * t) >> 30) / 64'd2;
        t   = (sub > Q30_ONE_U) ? 64'd0 : Q30_ONE_U - sub;
        return t;
    endfunction

    // Cosine of g/2^32 turns, signed Q30, folded into the first quadrant
    function automatic longint turn_cos(input logic [31:0] g);
        logic [63:0] r;
        logic [63:0] arg;
        longint      c;
        r   = {34'd0, g[29:0]};
        arg = g[30] ? (64'h4000_0000 - r) : r;
        c   = longint'(quarter_cos(arg));
        if (g[31] ^ g[30])
        begin
            c = -c;
        end
        return c;
    endfunction

    // Q15 Hamming weight for an angle of g/2^32 turns
    function automatic logic [WIN_W-1:0] win_entry(input logic [31:0] g);
        longint acc;
        acc = HAM_A_Q30 * Q30_ONE - HAM_B_Q30 * turn_cos(g) + (64'sd1 <<< 44);
        if (acc < 0)
        begin
            acc = 0;
        end
        return WIN_W'(acc >>> 45);
    endfunction

endpackage

>>> design/preemphasis_hamming_framer_top.sv
// Top level of the pre-emphasis and Hamming-window framer.
// Usage:
//   Input channel (in_valid/in_ready): one signed 16-bit sample per beat, with
//   start_of_stream high on the first sample of a stream; it clears the previous
//   sample and restarts framing, dropping any partial frame.
//   Output channel (out_valid/out_ready): one beat per sample once the first half
//   frame is filled, carrying the windowed value at position k of the current frame,
//   the windowed new value at k+HOP, k itself and frame_end on the last beat.
//   APB port: register 0 is the Q15 pre-emphasis coefficient (reset 31130).
// Timing:
//   A result passes stages a, b, c and the output register. One sample per cycle
//   is sustained while out_ready is high; the half-frame buffer RAM does one read
//   and one write per sample on separate ports; both window weights are read at once.
// Reset:
//   Clears framing and pipeline state; buffer contents stay undefined and are never
//   read before they are written.
// Stall:
//   While out_ready is low the pipeline holds its results in place and keeps taking
//   samples until its three internal stages are full; then in_ready drops.
module preemphasis_hamming_framer_top #(
    parameter int FRAME_LEN = phf_pkg::FRAME_LEN_DEF,
    parameter int HOP       = phf_pkg::HOP_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [phf_pkg::SAMPLE_W-1:0] sample,
    input  logic                                start_of_stream,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [phf_pkg::VALUE_W-1:0]  early_value,
    output logic signed [phf_pkg::VALUE_W-1:0]  late_value,
    output logic        [phf_pkg::POS_W-1:0]    position,
    output logic                                frame_end,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [phf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic        [phf_pkg::APB_DATA_W-1:0] pwdata,
    output logic        [phf_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);
    import phf_pkg::*;

    localparam int KW = $clog2(HOP);
    localparam int RA = $clog2(FRAME_LEN);
    localparam int IW = $clog2(FRAME_LEN + 2 * HOP) + 1;
    localparam int MP_W = 2 * SAMPLE_W;

    // Configuration
    logic [COEFF_W-1:0] coeff;

    phf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coeff   (coeff)
    );

    // Framing state
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic        [KW-1:0]       half_pos_reg;
    logic        [KW-1:0]       half_pos_next;
    logic                       filled_reg;
    logic                       filled_next;

    // Pipeline occupancy
    logic va_reg, va_next;
    logic vb_reg, vb_next;
    logic vc_reg, vc_next;
    logic ov_reg, ov_next;

    logic accept, out_take;
    logic a_move, b_move, c_move;
    logic a_free, b_free, c_free, out_free;

    // Sample-side view after a start of stream
    logic                       sos;
    logic signed [SAMPLE_W-1:0] prev_eff;
    logic        [KW-1:0]       k_eff;
    logic                       filled_eff;
    logic                       last_k;
    logic        [IW-1:0]       early_idx;
    logic        [IW-1:0]       late_idx;
    logic                       early_ok;
    logic                       late_ok;
    logic signed [MP_W-1:0]     pre_prod;

    // Stage a: accepted sample, coefficient product, memory reads in flight
    logic signed [SAMPLE_W-1:0] sample_a_reg;
    logic signed [MP_W-1:0]     prod_a_reg;
    logic        [KW-1:0]       k_a_reg;
    logic                       emit_a_reg;
    logic                       ok_e_a_reg;
    logic                       ok_l_a_reg;
    logic signed [MP_W-1:0]     pre_round;
    logic signed [VALUE_W-1:0]  y_a;

    // Stage b: operands of the window products
    logic signed [VALUE_W-1:0]  y_b_reg;
    logic signed [VALUE_W-1:0]  buf_b_reg;
    logic        [WIN_W-1:0]    we_b_reg;
    logic        [WIN_W-1:0]    wl_b_reg;
    logic        [KW-1:0]       k_b_reg;
    logic                       emit_b_reg;

    // Stage c: raw products
    logic signed [PROD_W-1:0]   early_c_reg;
    logic signed [PROD_W-1:0]   late_c_reg;
    logic        [KW-1:0]       k_c_reg;
    logic signed [PROD_W-1:0]   early_round;
    logic signed [PROD_W-1:0]   late_round;

    // Output register
    logic signed [VALUE_W-1:0]  early_value_reg;
    logic signed [VALUE_W-1:0]  late_value_reg;
    logic        [POS_W-1:0]    position_reg;
    logic                       frame_end_reg;

    // Memory ports
    logic [VALUE_W-1:0] buf_rdata;
    logic [WIN_W-1:0]   win_early;
    logic [WIN_W-1:0]   win_late;
    logic               ram_we;

    // Handshake and stage movement; a non-emitting sample retires at stage b
    assign accept   = in_valid && in_ready;
    assign out_take = ov_reg && out_ready;
    assign out_free = !ov_reg || out_ready;
    assign c_move   = vc_reg && out_free;
    assign c_free   = !vc_reg || out_free;
    assign b_move   = vb_reg && (!emit_b_reg || c_free);
    assign b_free   = !vb_reg || b_move;
    assign a_move   = va_reg && b_free;
    assign a_free   = !va_reg || b_free;
    assign in_ready = a_free;

    // Apply start of stream before the sample is used
    assign sos        = start_of_stream;
    assign prev_eff   = sos ? '0 : prev_reg;
    assign k_eff      = sos ? '0 : half_pos_reg;
    assign filled_eff = !sos && filled_reg;
    assign last_k     = (k_eff == KW'(HOP - 1));
    assign early_idx  = IW'(k_eff);
    assign late_idx   = IW'(k_eff) + IW'(HOP);
    assign early_ok   = (early_idx < IW'(FRAME_LEN));
    assign late_ok    = (late_idx < IW'(FRAME_LEN));
    assign pre_prod   = $signed({1'b0, coeff}) * prev_eff;

    // Advance framing position on each accepted sample
    always_comb
    begin
        half_pos_next = half_pos_reg;
        filled_next   = filled_reg;
        if (accept)
        begin
            if (last_k)
            begin
                half_pos_next = '0;
                filled_next   = 1'b1;
            end
            else
            begin
                half_pos_next = k_eff + KW'(1);
                filled_next   = filled_eff;
            end
        end
    end

    // Track occupancy of each stage
    always_comb
    begin
        va_next = accept ? 1'b1 : (a_move ? 1'b0 : va_reg);
        vb_next = a_move ? 1'b1 : (b_move ? 1'b0 : vb_reg);
        vc_next = (b_move && emit_b_reg) ? 1'b1 : (c_move ? 1'b0 : vc_reg);
        ov_next = c_move ? 1'b1 : (out_take ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= '0;
            half_pos_reg <= '0;
            filled_reg   <= 1'b0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            vc_reg       <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prev_reg <= sample;
            end
            half_pos_reg <= half_pos_next;
            filled_reg   <= filled_next;
            va_reg       <= va_next;
            vb_reg       <= vb_next;
            vc_reg       <= vc_next;
            ov_reg       <= ov_next;
        end
    end

    // Stage a capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_a_reg <= sample;
            prod_a_reg   <= pre_prod;
            k_a_reg      <= k_eff;
            emit_a_reg   <= filled_eff;
            ok_e_a_reg   <= early_ok;
            ok_l_a_reg   <= late_ok;
        end
    end

    // Half-frame buffer: read position k at accept, write the new value back at a_move.
    // The next read of the same entry comes a half frame later, so no forwarding.
    assign ram_we = a_move;

    phf_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (HOP)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (k_a_reg),
        .wdata (y_a),
        .re    (accept),
        .raddr (k_eff),
        .rdata (buf_rdata)
    );

    phf_win_rom #(
        .FRAME_LEN (FRAME_LEN)
    ) u_win (
        .clk        (clk),
        .rd_en      (accept),
        .addr_early (early_ok ? early_idx[RA-1:0] : '0),
        .addr_late  (late_ok ? late_idx[RA-1:0] : '0),
        .win_early  (win_early),
        .win_late   (win_late)
    );

    // Pre-emphasis: subtract the rounded coefficient product
    assign pre_round = (prod_a_reg + MP_W'(16384)) >>> 15;
    assign y_a       = {sample_a_reg[SAMPLE_W-1], sample_a_reg} - pre_round[VALUE_W-1:0];

    // Stage b capture; zero weight for positions beyond the frame
    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            y_b_reg    <= y_a;
            buf_b_reg  <= buf_rdata;
            we_b_reg   <= ok_e_a_reg ? win_early : '0;
            wl_b_reg   <= ok_l_a_reg ? win_late : '0;
            k_b_reg    <= k_a_reg;
            emit_b_reg <= emit_a_reg;
        end
    end

    // Stage c: window products
    always_ff @(posedge clk)
    begin
        if (b_move && emit_b_reg)
        begin
            early_c_reg <= PROD_W'(buf_b_reg * $signed({1'b0, we_b_reg}));
            late_c_reg  <= PROD_W'(y_b_reg * $signed({1'b0, wl_b_reg}));
            k_c_reg     <= k_b_reg;
        end
    end

    // Round half up into the output register
    assign early_round = (early_c_reg + PROD_W'(16384)) >>> 15;
    assign late_round  = (late_c_reg + PROD_W'(16384)) >>> 15;

    always_ff @(posedge clk)
    begin
        if (c_move)
        begin
            early_value_reg <= early_round[VALUE_W-1:0];
            late_value_reg  <= late_round[VALUE_W-1:0];
            position_reg    <= POS_W'(k_c_reg);
            frame_end_reg   <= (k_c_reg == KW'(HOP - 1));
        end
    end

    assign out_valid   = ov_reg;
    assign early_value = early_value_reg;
    assign late_value  = late_value_reg;
    assign position    = position_reg;
    assign frame_end   = frame_end_reg;

`ifndef SYNTHESIS
    // An emitting read never hits the entry being written back in the same cycle
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && accept && filled_eff) |-> (k_a_reg != k_eff))
        else $error("buffer read and write collide on one entry");

    // A start of stream always restarts the first half fill
    a_sos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && start_of_stream) |=> (!filled_reg && (half_pos_reg == KW'(1))))
        else $error("start of stream did not restart framing");

    // Stage c only ever holds samples that emit
    a_c_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (b_move && !emit_b_reg) |=> (vc_reg == $past(vc_reg && !c_move)))
        else $error("non-emitting sample entered the product stage");
`endif

endmodule

>>> design/phf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module phf_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/phf_win_rom.sv
// Hamming window table with two registered read ports.
module phf_win_rom #(
    parameter int FRAME_LEN = phf_pkg::FRAME_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [$clog2(FRAME_LEN)-1:0] addr_early,
    input  logic [$clog2(FRAME_LEN)-1:0] addr_late,
    output logic [phf_pkg::WIN_W-1:0]    win_early,
    output logic [phf_pkg::WIN_W-1:0]    win_late
);
    import phf_pkg::*;

    logic [WIN_W-1:0] win_tab [FRAME_LEN];
    logic [WIN_W-1:0] win_early_reg;
    logic [WIN_W-1:0] win_late_reg;

    // Build each weight at elaboration: angle n/(FRAME_LEN-1) of a turn
    for (genvar n = 0; n < FRAME_LEN; n++)
    begin : g_tab
        localparam logic [63:0] ANGLE =
            ((64'(n) << 32) / 64'(FRAME_LEN - 1)) & 64'hFFFF_FFFF;
        localparam logic [WIN_W-1:0] WEIGHT = win_entry(ANGLE[31:0]);
        assign win_tab[n] = WEIGHT;
    end

    // Read both weights of one sample
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            win_early_reg <= win_tab[addr_early];
            win_late_reg  <= win_tab[addr_late];
        end
    end

    assign win_early = win_early_reg;
    assign win_late  = win_late_reg;

endmodule

>>> design/phf_cfg.sv
// APB register block holding the pre-emphasis coefficient.
module phf_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [phf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [phf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [phf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output logic [phf_pkg::COEFF_W-1:0]        coeff
);
    import phf_pkg::*;

    logic               reg_index;
    logic [COEFF_W-1:0] coeff_reg;
    logic [COEFF_W-1:0] coeff_next;

    // Registers sit at 4-byte steps
    assign reg_index = paddr[2];

    // Take a write in the access phase
    always_comb
    begin
        coeff_next = coeff_reg;
        if (psel && penable && pwrite && (reg_index == REG_PREEMPH_COEFF))
        begin
            coeff_next = pwdata[COEFF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= COEFF_RESET;
        end
        else
        begin
            coeff_reg <= coeff_next;
        end
    end

    // Read back; unmapped addresses read zero
    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_PREEMPH_COEFF)
        begin
            prdata = {{(APB_DATA_W - COEFF_W){1'b0}}, coeff_reg};
        end
    end

    assign pready = 1'b1;
    assign coeff  = coeff_reg;

endmodule
